// File: src/gac_pkg.sv
`timescale 1ns / 1ps
// Shared types, sizes and codes of the glyph atlas cache.
// Depends on nothing; every other file of the block imports it.
package gac_pkg;

   localparam int TEXTURE_SIZE   = 1024;
   localparam int MAX_SHELVES    = 64;
   localparam int TABLE_SLOTS    = 1024;
   localparam int FONT_KEY_BYTES = 8;

   localparam int POS_W  = $clog2(TEXTURE_SIZE);
   localparam int DIM_W  = POS_W + 1;
   localparam int SUM_W  = DIM_W + 2;
   localparam int SLOT_W = $clog2(TABLE_SLOTS);
   localparam int SH_W   = (MAX_SHELVES > 1) ? $clog2(MAX_SHELVES) : 1;
   localparam int SC_W   = $clog2(MAX_SHELVES + 1);
   localparam int USED_LIMIT = TABLE_SLOTS * 3 / 4;

   localparam int HASH_BYTES = FONT_KEY_BYTES + 8;
   localparam int HKEY_W     = HASH_BYTES * 8;
   localparam int HCNT_W     = $clog2(HASH_BYTES);
   localparam logic [31:0] FNV_BASIS = 32'd2166136261;
   localparam logic [31:0] FNV_PRIME = 32'd16777619;

   localparam logic [1:0] ACT_LOOKUP    = 2'd0;
   localparam logic [1:0] ACT_INSERT    = 2'd1;
   localparam logic [1:0] ACT_EMPTY     = 2'd2;
   localparam logic [1:0] ACT_UNDEFINED = 2'd3;

   localparam logic [2:0] RES_OK        = 3'd0;
   localparam logic [2:0] RES_MISS      = 3'd1;
   localparam logic [2:0] RES_BAD_SIZE  = 3'd2;
   localparam logic [2:0] RES_TOO_LARGE = 3'd3;
   localparam logic [2:0] RES_FULL      = 3'd4;

   typedef struct packed {
      logic [1:0]         action;
      logic [63:0]        font_key;
      logic [31:0]        glyph_index;
      logic [31:0]        color;
      logic [10:0]        glyph_width;
      logic [10:0]        glyph_height;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic               is_centered;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [9:0]         region_x;
      logic [9:0]         region_y;
      logic [10:0]        region_w;
      logic [10:0]        region_h;
      logic signed [15:0] stored_offset_x;
      logic signed [15:0] stored_offset_y;
      logic               stored_centered;
      logic               evicted;
   } rsp_type;

   typedef struct packed {
      logic [9:0]         region_x;
      logic [9:0]         region_y;
      logic [10:0]        region_w;
      logic [10:0]        region_h;
      logic signed [15:0] offset_x;
      logic signed [15:0] offset_y;
      logic               centered;
   } attr_type;

   typedef struct packed {
      logic        valid;
      logic [63:0] font_key;
      logic [31:0] glyph_index;
      logic [31:0] color;
      attr_type    attrs;
   } slot_type;

   typedef struct packed {
      logic [POS_W-1:0] top;
      logic [POS_W-1:0] height;
      logic [DIM_W-1:0] cursor;
   } shelf_type;

   typedef struct packed {
      logic        done;
      logic [31:0] hash;
   } hash_rsp_type;

endpackage

// File: src/gac_fnv.sv
`timescale 1ns / 1ps
// Iterative FNV-1a hash unit: one key byte and one multiply per cycle.
// Depends on gac_pkg.
module gac_fnv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  gac_pkg::req_type      key,
   output gac_pkg::hash_rsp_type result
);
   import gac_pkg::*;

   logic [31:0]       hash_ff;
   logic [HKEY_W-1:0] bytes_ff;
   logic [HCNT_W-1:0] cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [31:0]       mixed;
   logic [31:0]       hash_in;

   assign mixed   = hash_ff ^ {24'd0, bytes_ff[7:0]};
   assign hash_in = mixed * FNV_PRIME;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            hash_ff  <= FNV_BASIS;
            bytes_ff <= {key.color, key.glyph_index, key.font_key[FONT_KEY_BYTES*8-1:0]};
            cnt_ff   <= '0;
            busy_ff  <= 1'b1;
         end else if (busy_ff) begin
            hash_ff  <= hash_in;
            bytes_ff <= bytes_ff >> 8;
            cnt_ff   <= cnt_ff + 1'b1;
            if (cnt_ff == HCNT_W'(HASH_BYTES - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign result.done = done_ff;
   assign result.hash = hash_ff;

endmodule

// File: src/glyph_atlas_cache.sv
`timescale 1ns / 1ps
// Glyph atlas cache top level: sequencer, slot table and shelf store.
// Depends on gac_pkg and gac_fnv.
//
//   Channel   Direction  Handshake               Beat
//   req_      in         req_valid / req_stall   req_type
//   rsp_      out        rsp_valid / rsp_stall   rsp_type
//
// An item first hashes its key at one byte a cycle, then probes slots, each in a read and
// a check state, and examines shelves the same way, besides the dispatch, place and output
// states that emit the result; the byte-wide hash step and the slot memory port set its pace.
// A flush sweeps the slot table at one entry a cycle, clearing every slot.
// After reset the same sweep runs before the first beat is taken.
// A new beat is taken while a finished result still waits on rsp_stall.
module glyph_atlas_cache (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gac_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gac_pkg::rsp_type rsp_data
);
   import gac_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_HASH, ST_DISPATCH, ST_PLACE, ST_SH_RD, ST_SH_CK,
      ST_SH_NEW, ST_LK_RD, ST_LK_CK, ST_FR_RD, ST_FR_CK, ST_WRITE, ST_OUT
   } state_type;

   state_type        state_ff;
   state_type        ret_ff;
   req_type          req_ff;
   logic [31:0]      hash_ff;
   logic [SLOT_W-1:0] probe_ff;
   logic [SLOT_W:0]   cnt_ff;
   logic [SLOT_W-1:0] clr_ff;
   logic [SLOT_W:0]   used_ff;
   logic [SC_W-1:0]   sidx_ff;
   logic [SC_W-1:0]   count_ff;
   logic [DIM_W-1:0]  top_ff;
   logic              retry_ff;
   logic              ev_ff;
   logic [2:0]        status_ff;
   attr_type          attr_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_ff;

   slot_type  slot_mem [TABLE_SLOTS];
   slot_type  slot_rd_ff;
   shelf_type shelf_mem [MAX_SHELVES];
   shelf_type shelf_rd_ff;

   hash_rsp_type hres;
   logic         hash_start;

   logic [DIM_W:0]    pw;
   logic [DIM_W:0]    ph;
   logic              fit;
   logic              new_ok;
   logic              key_hit;
   logic              slot_we;
   logic [SLOT_W-1:0] slot_waddr;
   slot_type          slot_wdata;
   logic              shelf_we;
   logic [SH_W-1:0]   shelf_waddr;
   shelf_type         shelf_wdata;
   logic              out_free;
   attr_type          new_attr;

   assign hash_start = (state_ff == ST_IDLE) && req_valid;

   gac_fnv u_fnv (
      .clock  (clock),
      .reset  (reset),
      .start  (hash_start),
      .key    (req_data),
      .result (hres)
   );

   assign pw = {1'b0, req_ff.glyph_width} + 1'b1;
   assign ph = {1'b0, req_ff.glyph_height} + 1'b1;

   assign fit = ({1'b0, shelf_rd_ff.height} >= req_ff.glyph_height) &&
                (({2'b00, shelf_rd_ff.cursor} + {1'b0, pw}) <= SUM_W'(TEXTURE_SIZE));
   assign new_ok = (count_ff < SC_W'(MAX_SHELVES)) &&
                   (({2'b00, top_ff} + {1'b0, ph}) <= SUM_W'(TEXTURE_SIZE)) &&
                   ({1'b0, pw} <= SUM_W'(TEXTURE_SIZE));
   assign key_hit = (slot_rd_ff.font_key == req_ff.font_key) &&
                    (slot_rd_ff.glyph_index == req_ff.glyph_index) &&
                    (slot_rd_ff.color == req_ff.color);

   always_comb begin
      new_attr          = '0;
      new_attr.region_x = (state_ff == ST_SH_CK) ? shelf_rd_ff.cursor[POS_W-1:0] : '0;
      new_attr.region_y = (state_ff == ST_SH_CK) ? shelf_rd_ff.top : top_ff[POS_W-1:0];
      new_attr.region_w = req_ff.glyph_width;
      new_attr.region_h = req_ff.glyph_height;
      new_attr.offset_x = req_ff.offset_x;
      new_attr.offset_y = req_ff.offset_y;
      new_attr.centered = req_ff.is_centered;
   end

   always_comb begin
      slot_we    = (state_ff == ST_CLEAR) || (state_ff == ST_WRITE);
      slot_waddr = (state_ff == ST_CLEAR) ? clr_ff : probe_ff;
      slot_wdata = '0;
      if (state_ff == ST_WRITE) begin
         slot_wdata.valid       = 1'b1;
         slot_wdata.font_key    = req_ff.font_key;
         slot_wdata.glyph_index = req_ff.glyph_index;
         slot_wdata.color       = req_ff.color;
         slot_wdata.attrs       = attr_ff;
      end
   end

   always_comb begin
      shelf_we    = 1'b0;
      shelf_waddr = sidx_ff[SH_W-1:0];
      shelf_wdata = shelf_rd_ff;
      if (state_ff == ST_SH_CK && fit) begin
         shelf_we           = 1'b1;
         shelf_wdata.cursor = DIM_W'({1'b0, shelf_rd_ff.cursor} + pw);
      end else if (state_ff == ST_SH_NEW && new_ok) begin
         shelf_we           = 1'b1;
         shelf_waddr        = count_ff[SH_W-1:0];
         shelf_wdata.top    = top_ff[POS_W-1:0];
         shelf_wdata.height = req_ff.glyph_height[POS_W-1:0];
         shelf_wdata.cursor = pw[DIM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (slot_we) begin
         slot_mem[slot_waddr] <= slot_wdata;
      end
      slot_rd_ff <= slot_mem[probe_ff];
   end

   always_ff @(posedge clock) begin
      if (shelf_we) begin
         shelf_mem[shelf_waddr] <= shelf_wdata;
      end
      shelf_rd_ff <= shelf_mem[sidx_ff[SH_W-1:0]];
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ret_ff       <= ST_IDLE;
         clr_ff       <= '0;
         used_ff      <= '0;
         count_ff     <= '0;
         top_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == SLOT_W'(TABLE_SLOTS - 1)) begin
                  state_ff <= ret_ff;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  req_ff   <= req_data;
                  state_ff <= ST_HASH;
               end
            end
            ST_HASH: begin
               if (hres.done) begin
                  hash_ff  <= hres.hash;
                  state_ff <= ST_DISPATCH;
               end
            end
            ST_DISPATCH: begin
               ev_ff    <= 1'b0;
               retry_ff <= 1'b0;
               attr_ff  <= '0;
               probe_ff <= hash_ff[SLOT_W-1:0];
               cnt_ff   <= '0;
               if (req_ff.action == ACT_LOOKUP) begin
                  state_ff <= ST_LK_RD;
               end else if (req_ff.action != ACT_INSERT && req_ff.action != ACT_EMPTY) begin
                  status_ff <= RES_MISS;
                  state_ff  <= ST_OUT;
               end else if (req_ff.action == ACT_INSERT &&
                            (req_ff.glyph_width == '0 || req_ff.glyph_height == '0)) begin
                  status_ff <= RES_BAD_SIZE;
                  state_ff  <= ST_OUT;
               end else if (used_ff >= (SLOT_W + 1)'(USED_LIMIT)) begin
                  ev_ff    <= 1'b1;
                  used_ff  <= '0;
                  count_ff <= '0;
                  top_ff   <= '0;
                  clr_ff   <= '0;
                  ret_ff   <= ST_PLACE;
                  state_ff <= ST_CLEAR;
               end else begin
                  state_ff <= ST_PLACE;
               end
            end
            ST_PLACE: begin
               sidx_ff <= '0;
               if (req_ff.action == ACT_EMPTY) begin
                  state_ff <= ST_FR_RD;
               end else begin
                  state_ff <= ST_SH_RD;
               end
            end
            ST_SH_RD: begin
               if (sidx_ff == count_ff) begin
                  state_ff <= ST_SH_NEW;
               end else begin
                  state_ff <= ST_SH_CK;
               end
            end
            ST_SH_CK: begin
               if (fit) begin
                  attr_ff  <= new_attr;
                  state_ff <= ST_FR_RD;
               end else begin
                  sidx_ff  <= sidx_ff + 1'b1;
                  state_ff <= ST_SH_RD;
               end
            end
            ST_SH_NEW: begin
               if (new_ok) begin
                  attr_ff  <= new_attr;
                  count_ff <= count_ff + 1'b1;
                  top_ff   <= DIM_W'({1'b0, top_ff} + ph);
                  state_ff <= ST_FR_RD;
               end else if (!retry_ff) begin
                  retry_ff <= 1'b1;
                  ev_ff    <= 1'b1;
                  used_ff  <= '0;
                  count_ff <= '0;
                  top_ff   <= '0;
                  clr_ff   <= '0;
                  ret_ff   <= ST_PLACE;
                  state_ff <= ST_CLEAR;
               end else begin
                  status_ff <= RES_TOO_LARGE;
                  state_ff  <= ST_OUT;
               end
            end
            ST_LK_RD: begin
               if (cnt_ff == (SLOT_W + 1)'(TABLE_SLOTS)) begin
                  status_ff <= RES_MISS;
                  state_ff  <= ST_OUT;
               end else begin
                  state_ff <= ST_LK_CK;
               end
            end
            ST_LK_CK: begin
               if (!slot_rd_ff.valid) begin
                  status_ff <= RES_MISS;
                  state_ff  <= ST_OUT;
               end else if (key_hit) begin
                  status_ff <= RES_OK;
                  attr_ff   <= slot_rd_ff.attrs;
                  state_ff  <= ST_OUT;
               end else begin
                  probe_ff <= probe_ff + 1'b1;
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= ST_LK_RD;
               end
            end
            ST_FR_RD: begin
               if (cnt_ff == (SLOT_W + 1)'(TABLE_SLOTS)) begin
                  status_ff <= RES_FULL;
                  attr_ff   <= '0;
                  state_ff  <= ST_OUT;
               end else begin
                  state_ff <= ST_FR_CK;
               end
            end
            ST_FR_CK: begin
               if (!slot_rd_ff.valid) begin
                  state_ff <= ST_WRITE;
               end else begin
                  probe_ff <= probe_ff + 1'b1;
                  cnt_ff   <= cnt_ff + 1'b1;
                  state_ff <= ST_FR_RD;
               end
            end
            ST_WRITE: begin
               used_ff   <= used_ff + 1'b1;
               status_ff <= RES_OK;
               state_ff  <= ST_OUT;
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_ff.status          <= status_ff;
                  rsp_ff.region_x        <= attr_ff.region_x;
                  rsp_ff.region_y        <= attr_ff.region_y;
                  rsp_ff.region_w        <= attr_ff.region_w;
                  rsp_ff.region_h        <= attr_ff.region_h;
                  rsp_ff.stored_offset_x <= attr_ff.offset_x;
                  rsp_ff.stored_offset_y <= attr_ff.offset_y;
                  rsp_ff.stored_centered <= attr_ff.centered;
                  rsp_ff.evicted         <= ev_ff;
                  state_ff               <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside the output step");

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= (SLOT_W + 1)'(USED_LIMIT))
      else $error("slot use passed the load limit");

   a_shelf_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= SC_W'(MAX_SHELVES))
      else $error("shelf count passed its limit");

   a_too_large_evicts: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == RES_TOO_LARGE |-> rsp_ff.evicted)
      else $error("too large without a flush");

   a_hash_in_step: assert property (@(posedge clock) disable iff (reset)
      hres.done |-> state_ff == ST_HASH)
      else $error("hash finished outside the hash step");

endmodule

// File: dv/glyph_atlas_cache_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of glyph_atlas_cache: a table of directed beats, then random ones.
// Each result beat is compared with the row's expected answer or, where the row gives none,
// with a behavioural model of the cache held here. Depends on gac_pkg and the glyph_atlas_cache RTL.
module glyph_atlas_cache_tb;
   import gac_pkg::*;

   localparam int RANDOM_ITEMS = 1330;
   localparam int WATCHDOG_LIMIT = 40000;

   typedef struct {
      req_type beat;
      bit      typed;
      rsp_type answer;
   } stim_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   glyph_atlas_cache uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Model state of the cache.
   bit          m_valid [TABLE_SLOTS];
   logic [63:0] m_font [TABLE_SLOTS];
   logic [31:0] m_gid [TABLE_SLOTS];
   logic [31:0] m_col [TABLE_SLOTS];
   rsp_type     m_attr [TABLE_SLOTS];
   int          m_shelf_y [MAX_SHELVES];
   int          m_shelf_h [MAX_SHELVES];
   int          m_shelf_cur [MAX_SHELVES];
   int          m_shelf_count;
   int          m_next_top;
   int          m_used;

   stim_row_type stim [$];
   rsp_type     pending_rsp [$];
   req_type     key_pool [$];
   int          next_item;
   int          failures;
   int          quiet_cycles;

   function automatic logic [31:0] glyph_hash(req_type r);
      logic [31:0]  h;
      logic [127:0] k;
      h = FNV_BASIS;
      k = {r.color, r.glyph_index, r.font_key};
      for (int i = 0; i < 16; i++) begin
         h = (h ^ {24'd0, k[8*i +: 8]}) * FNV_PRIME;
      end
      return h;
   endfunction

   function automatic void flush_cache();
      for (int i = 0; i < TABLE_SLOTS; i++) m_valid[i] = 0;
      m_used = 0;
      m_shelf_count = 0;
      m_next_top = 0;
   endfunction

   function automatic bit place_glyph(int w, int h, output int px, output int py);
      px = 0;
      py = 0;
      for (int i = 0; i < m_shelf_count; i++) begin
         if (m_shelf_h[i] >= h && m_shelf_cur[i] + w + 1 <= TEXTURE_SIZE) begin
            px = m_shelf_cur[i];
            py = m_shelf_y[i];
            m_shelf_cur[i] += w + 1;
            return 1;
         end
      end
      if (m_shelf_count >= MAX_SHELVES) return 0;
      if (m_next_top + h + 1 > TEXTURE_SIZE || w + 1 > TEXTURE_SIZE) return 0;
      m_shelf_y[m_shelf_count] = m_next_top;
      m_shelf_h[m_shelf_count] = h;
      m_shelf_cur[m_shelf_count] = w + 1;
      py = m_next_top;
      m_shelf_count++;
      m_next_top += h + 1;
      return 1;
   endfunction

   function automatic rsp_type cache_response(req_type r);
      rsp_type     o;
      rsp_type     a;
      logic [31:0] hv;
      int          base, idx, slot, px, py;
      bit          placed;
      o = '0;
      o.status = RES_MISS;
      hv = glyph_hash(r);
      base = hv % TABLE_SLOTS;
      if (r.action == ACT_LOOKUP) begin
         for (int p = 0; p < TABLE_SLOTS; p++) begin
            idx = (base + p) % TABLE_SLOTS;
            if (!m_valid[idx]) break;
            if (m_font[idx] == r.font_key && m_gid[idx] == r.glyph_index &&
                m_col[idx] == r.color) begin
               o = m_attr[idx];
               return o;
            end
         end
         return o;
      end
      if (r.action != ACT_INSERT && r.action != ACT_EMPTY) return o;
      if (r.action == ACT_INSERT && (r.glyph_width == 0 || r.glyph_height == 0)) begin
         o.status = RES_BAD_SIZE;
         return o;
      end
      if (m_used >= USED_LIMIT) begin
         flush_cache();
         o.evicted = 1'b1;
      end
      a = '0;
      if (r.action == ACT_INSERT) begin
         placed = place_glyph(r.glyph_width, r.glyph_height, px, py);
         if (!placed) begin
            flush_cache();
            o.evicted = 1'b1;
            placed = place_glyph(r.glyph_width, r.glyph_height, px, py);
            if (!placed) begin
               o.status = RES_TOO_LARGE;
               return o;
            end
         end
         a.region_x = px[9:0];
         a.region_y = py[9:0];
         a.region_w = r.glyph_width;
         a.region_h = r.glyph_height;
         a.stored_offset_x = r.offset_x;
         a.stored_offset_y = r.offset_y;
         a.stored_centered = r.is_centered;
      end
      slot = -1;
      for (int p = 0; p < TABLE_SLOTS; p++) begin
         idx = (base + p) % TABLE_SLOTS;
         if (!m_valid[idx]) begin
            slot = idx;
            break;
         end
      end
      if (slot < 0) begin
         o.status = RES_FULL;
         return o;
      end
      m_valid[slot] = 1;
      m_font[slot] = r.font_key;
      m_gid[slot] = r.glyph_index;
      m_col[slot] = r.color;
      m_attr[slot] = a;
      m_used++;
      a.status = RES_OK;
      a.evicted = o.evicted;
      return a;
   endfunction

   task automatic check_beat(rsp_type got, rsp_type want);
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         failures++;
      end
      if (got.region_x !== want.region_x) begin
         $error("region_x: expected %0d, got %0d", want.region_x, got.region_x);
         failures++;
      end
      if (got.region_y !== want.region_y) begin
         $error("region_y: expected %0d, got %0d", want.region_y, got.region_y);
         failures++;
      end
      if (got.region_w !== want.region_w) begin
         $error("region_w: expected %0d, got %0d", want.region_w, got.region_w);
         failures++;
      end
      if (got.region_h !== want.region_h) begin
         $error("region_h: expected %0d, got %0d", want.region_h, got.region_h);
         failures++;
      end
      if (got.stored_offset_x !== want.stored_offset_x) begin
         $error("stored_offset_x: expected %0d, got %0d",
                want.stored_offset_x, got.stored_offset_x);
         failures++;
      end
      if (got.stored_offset_y !== want.stored_offset_y) begin
         $error("stored_offset_y: expected %0d, got %0d",
                want.stored_offset_y, got.stored_offset_y);
         failures++;
      end
      if (got.stored_centered !== want.stored_centered) begin
         $error("stored_centered: expected %0d, got %0d",
                want.stored_centered, got.stored_centered);
         failures++;
      end
      if (got.evicted !== want.evicted) begin
         $error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
         failures++;
      end
   endtask

   function automatic req_type make_beat(logic [1:0] act, logic [63:0] f, logic [31:0] g,
                                         logic [31:0] c, int w, int h, int ox, int oy,
                                         bit cen);
      req_type r;
      r.action = act;
      r.font_key = f;
      r.glyph_index = g;
      r.color = c;
      r.glyph_width = w[10:0];
      r.glyph_height = h[10:0];
      r.offset_x = ox[15:0];
      r.offset_y = oy[15:0];
      r.is_centered = cen;
      return r;
   endfunction

   function automatic void add_row(req_type r, bit typed, rsp_type answer);
      stim_row_type s;
      s.beat = r;
      s.typed = typed;
      s.answer = answer;
      stim.push_back(s);
   endfunction

   function automatic rsp_type status_only(logic [2:0] st, bit ev);
      rsp_type o;
      o = '0;
      o.status = st;
      o.evicted = ev;
      return o;
   endfunction

   function automatic void build_directed();
      rsp_type first;
      logic [63:0] fa;
      fa = 64'h0123_4567_89AB_CDEF;
      first = '0;
      first.status = RES_OK;
      first.region_w = 11'd10;
      first.region_h = 11'd20;
      first.stored_offset_x = -16'sd32768;
      first.stored_offset_y = 16'sd32767;
      first.stored_centered = 1'b1;
      add_row(make_beat(ACT_LOOKUP, fa, 7, 9, 0, 0, 0, 0, 0), 1, status_only(RES_MISS, 0));
      add_row(make_beat(ACT_INSERT, fa, 7, 9, 10, 20, -32768, 32767, 1), 1, first);
      add_row(make_beat(ACT_LOOKUP, fa, 7, 9, 0, 0, 0, 0, 0), 1, first);
      add_row(make_beat(ACT_INSERT, fa, 8, 9, 0, 5, 1, 1, 1), 1, status_only(RES_BAD_SIZE, 0));
      add_row(make_beat(ACT_INSERT, fa, 8, 9, 5, 0, 1, 1, 1), 1, status_only(RES_BAD_SIZE, 0));
      add_row(make_beat(ACT_UNDEFINED, fa, 7, 9, 3, 3, 3, 3, 1), 1, status_only(RES_MISS, 0));
      add_row(make_beat(ACT_EMPTY, 64'd5, 32'd6, 32'd7, 0, 0, 55, -55, 1), 1,
              status_only(RES_OK, 0));
      add_row(make_beat(ACT_LOOKUP, 64'd5, 32'd6, 32'd7, 0, 0, 0, 0, 0), 0, '0);
      add_row(make_beat(ACT_INSERT, fa, 7, 9, 30, 40, 2, 3, 0), 0, '0);
      add_row(make_beat(ACT_INSERT, fa, 7, 9, 12, 12, 4, 5, 1), 0, '0);
      add_row(make_beat(ACT_LOOKUP, fa, 7, 9, 0, 0, 0, 0, 0), 0, '0);
      add_row(make_beat(ACT_INSERT, fa, 1, 1, 1025, 1, 0, 0, 0), 1,
              status_only(RES_TOO_LARGE, 1));
      add_row(make_beat(ACT_LOOKUP, fa, 7, 9, 0, 0, 0, 0, 0), 1, status_only(RES_MISS, 0));
      add_row(make_beat(ACT_INSERT, fa, 2, 2, 1023, 1, -1, -1, 1), 0, '0);
      add_row(make_beat(ACT_INSERT, fa, 3, 3, 1, 1023, 0, 0, 0), 0, '0);
      add_row(make_beat(ACT_INSERT, {64{1'b1}}, {32{1'b1}}, {32{1'b1}}, 1024, 1, 0, 0, 1), 1,
              status_only(RES_TOO_LARGE, 1));
      add_row(make_beat(ACT_INSERT, {64{1'b1}}, {32{1'b1}}, {32{1'b1}}, 2047, 2047,
                        32767, -32768, 1), 1, status_only(RES_TOO_LARGE, 1));
      add_row(make_beat(ACT_INSERT, {64{1'b1}}, {32{1'b1}}, {32{1'b1}}, 1, 1, 0, 0, 0), 0, '0);
      add_row(make_beat(ACT_LOOKUP, {64{1'b1}}, {32{1'b1}}, {32{1'b1}}, 0, 0, 0, 0, 0), 0, '0);
      add_row(make_beat(ACT_LOOKUP, 64'd0, 32'd0, 32'd0, 0, 0, 0, 0, 0), 1,
              status_only(RES_MISS, 0));
   endfunction

   function automatic int random_size();
      int p;
      p = $urandom_range(99);
      if (p < 88) return $urandom_range(12, 1);
      if (p < 97) return $urandom_range(1024, 1);
      return $urandom_range(2047, 1025);
   endfunction

   function automatic void build_random();
      req_type r;
      int      p;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         r = make_beat(ACT_LOOKUP, {$urandom, $urandom}, $urandom, $urandom,
                       random_size(), random_size(), $urandom, $urandom, $urandom_range(1));
         if (key_pool.size() > 0 && $urandom_range(99) < 70) begin
            p = $urandom_range(key_pool.size() - 1);
            r.font_key = key_pool[p].font_key;
            r.glyph_index = key_pool[p].glyph_index;
            r.color = key_pool[p].color;
         end
         p = $urandom_range(99);
         if (p < 38) begin
            r.action = ACT_LOOKUP;
         end else if (p < 83) begin
            r.action = ACT_INSERT;
            if ($urandom_range(99) < 3) r.glyph_width = 0;
            if ($urandom_range(99) < 3) r.glyph_height = 0;
         end else if (p < 97) begin
            r.action = ACT_EMPTY;
         end else begin
            r.action = ACT_UNDEFINED;
         end
         if (r.action == ACT_INSERT || r.action == ACT_EMPTY) key_pool.push_back(r);
         if (key_pool.size() > 400) void'(key_pool.pop_front());
         add_row(r, 0, '0);
      end
   endfunction

   function automatic int idle_phase(int item);
      return (item * 4) / stim.size();
   endfunction

   always @(posedge clock) begin : drive_and_check
      bit      took;
      int      ph;
      rsp_type want;
      rsp_type model;
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
         quiet_cycles = 0;
      end else begin
         took = req_valid && !req_stall;
         if (took) begin
            model = cache_response(req_data);
            pending_rsp.push_back(stim[next_item].typed ? stim[next_item].answer : model);
            next_item++;
         end
         ph = idle_phase(next_item);
         if (!req_valid || took) begin
            if (next_item < stim.size() &&
                !((ph == 1 && $urandom_range(99) < 78) || (ph == 3 && $urandom_range(99) < 23)))
            begin
               req_valid <= 1'b1;
               req_data <= stim[next_item].beat;
            end else begin
               req_valid <= 1'b0;
            end
         end
         rsp_stall <= (ph == 2 && $urandom_range(99) < 78) ||
                      (ph == 3 && $urandom_range(99) < 23);
         if (rsp_valid && !rsp_stall) begin
            if (pending_rsp.size() == 0) begin
               $error("result beat with nothing expected");
               failures++;
            end else begin
               want = pending_rsp.pop_front();
               check_beat(rsp_data, want);
            end
         end
         if (took || (rsp_valid && !rsp_stall)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      failures = 0;
      next_item = 0;
      flush_cache();
      build_directed();
      build_random();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (next_item == stim.size() && pending_rsp.size() == 0);
      repeat (200) @(posedge clock);
      if (failures == 0 && pending_rsp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
